[sv/article_read_bitmap_core_assert.svh]
// Assertion macros for the read bitmap core.
`ifndef ARTICLE_READ_BITMAP_CORE_ASSERT_SVH
`define ARTICLE_READ_BITMAP_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ARB_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define ARB_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/arb_pkg.sv]
`default_nettype none

package arb_pkg;

  localparam int ARB_MAX_ARTICLES = 4096;
  localparam int ARB_WORD_W       = 8;
  localparam int ARB_BIT_W        = $clog2(ARB_WORD_W);
  localparam int ARB_ALU_W        = 34;
  localparam int ARB_CNT_W        = 13;

  localparam logic [ARB_CNT_W-1:0] ARB_COUNT_MAX = 13'h1FFF;
  localparam logic [30:0]          ARB_WLO_RST   = 31'd0;
  localparam logic [30:0]          ARB_WHI_RST   = 31'd4095;

  localparam logic [2:0] OP_QUERY        = 3'd0;
  localparam logic [2:0] OP_MARK_READ    = 3'd1;
  localparam logic [2:0] OP_MARK_UNREAD  = 3'd2;
  localparam logic [2:0] OP_RANGE_READ   = 3'd3;
  localparam logic [2:0] OP_RANGE_UNREAD = 3'd4;
  localparam logic [2:0] OP_CLEAR        = 3'd5;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [30:0] article;
    logic [30:0] range_end;
  } arb_req_t;

  typedef struct packed {
    logic                 is_read;
    logic                 in_window;
    logic [ARB_CNT_W-1:0] unread_count;
  } arb_rsp_t;

endpackage

`default_nettype wire

[sv/arb_ram.sv]
`default_nettype none

module arb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/arb_alu.sv]
`default_nettype none

module arb_alu (
  input  logic [arb_pkg::ARB_ALU_W-1:0] a,
  input  logic [arb_pkg::ARB_ALU_W-1:0] b,
  input  logic                          sub,
  output logic [arb_pkg::ARB_ALU_W-1:0] res,
  output logic                          lt
);

  import arb_pkg::*;

  always_comb begin
    if (sub == ALU_SUB) begin
      res = a - b;
    end else begin
      res = a + b;
    end
  end

  assign lt = res[ARB_ALU_W-1];

endmodule

`default_nettype wire

[sv/article_read_bitmap_core.sv]
// Channel  | Handshake        | Payload         | Notes
// request  | start / busy     | req (arb_req_t) | taken when start & !busy
// result   | done             | rsp (arb_rsp_t) | one cycle, cannot stall
// config   | psel/penable/... | pwdata/prdata   | write in access phase, pready high
//
// Each request steps the shared adder/comparator through the window and clip
// arithmetic (CAP to AHI); a mark then clips its span (EHI, LOFF, ORD) and
// rewrites its 8-bit store words, updating the count (MOD, CNT); a clear
// writes all W = ceil(MAX_ARTICLES/8) store words (CLD, CLR); every request
// ends by reading the article's word (FRD, FIN). The bit store has one write
// and one read port. After reset a clearing pass over all W words runs with
// busy high. The result side has no stall; done marks each result for one cycle.
`default_nettype none
`include "article_read_bitmap_core_assert.svh"

module article_read_bitmap_core #(
  parameter int MAX_ARTICLES = arb_pkg::ARB_MAX_ARTICLES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  arb_pkg::arb_req_t req,
  output logic             done,
  output arb_pkg::arb_rsp_t rsp,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import arb_pkg::*;

  localparam int WORDS = (MAX_ARTICLES + ARB_WORD_W - 1) / ARB_WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  localparam logic REG_WINDOW_LOW  = 1'b0;
  localparam logic REG_WINDOW_HIGH = 1'b1;

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_CAP  = 4'd2;
  localparam logic [3:0] ST_EMP  = 4'd3;
  localparam logic [3:0] ST_HIC  = 4'd4;
  localparam logic [3:0] ST_ALO  = 4'd5;
  localparam logic [3:0] ST_AHI  = 4'd6;
  localparam logic [3:0] ST_CLD  = 4'd7;
  localparam logic [3:0] ST_CLR  = 4'd8;
  localparam logic [3:0] ST_EHI  = 4'd9;
  localparam logic [3:0] ST_LOFF = 4'd10;
  localparam logic [3:0] ST_ORD  = 4'd11;
  localparam logic [3:0] ST_MOD  = 4'd12;
  localparam logic [3:0] ST_CNT  = 4'd13;
  localparam logic [3:0] ST_FRD  = 4'd14;
  localparam logic [3:0] ST_FIN  = 4'd15;

  function automatic logic [ARB_BIT_W:0] popcount(input logic [ARB_WORD_W-1:0] w);
    logic [ARB_BIT_W:0] s;
    s = '0;
    for (int i = 0; i < ARB_WORD_W; i++) begin
      s = s + (ARB_BIT_W + 1)'(w[i]);
    end
    return s;
  endfunction

  logic [3:0]           state;
  logic [30:0]          wlo;
  logic [30:0]          whi;
  arb_req_t             req_q;
  logic [ARB_ALU_W-1:0] cap;
  logic [ARB_ALU_W-1:0] hi;
  logic                 has;
  logic                 in_lo;
  logic                 in_hi;
  logic                 end_gt_hi;
  logic [ARB_ALU_W-1:0] art_off;
  logic [ARB_ALU_W-1:0] first_off;
  logic [ARB_ALU_W-1:0] last_off;
  logic [AW-1:0]        widx;
  logic [ARB_BIT_W:0]   k;
  logic [ARB_CNT_W-1:0] unread_total;

  logic [ARB_ALU_W-1:0] alu_a;
  logic [ARB_ALU_W-1:0] alu_b;
  logic                 alu_sub;
  logic [ARB_ALU_W-1:0] alu_res;
  logic                 alu_lt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ARB_WORD_W-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [ARB_WORD_W-1:0] ram_rdata;

  logic                  single;
  logic                  mk_read;
  logic                  is_mark;
  logic                  art_in;
  logic                  cfg_wr;
  logic [ARB_ALU_W-1:0]  endv;
  logic [AW-1:0]         fw;
  logic [AW-1:0]         lw;
  logic [ARB_BIT_W-1:0]  lo_bit;
  logic [ARB_BIT_W-1:0]  hi_bit;
  logic [ARB_WORD_W-1:0] mask;
  logic [ARB_WORD_W-1:0] new_word;
  logic [ARB_BIT_W:0]    pop;
  logic [ARB_CNT_W-1:0]  cnt_load;

  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_WINDOW_LOW) ? {1'b0, wlo} : {1'b0, whi};

  assign single  = (req_q.op == OP_MARK_READ) || (req_q.op == OP_MARK_UNREAD);
  assign mk_read = (req_q.op == OP_MARK_READ) || (req_q.op == OP_RANGE_READ);
  assign is_mark = req_q.op inside {OP_MARK_READ, OP_MARK_UNREAD,
                                    OP_RANGE_READ, OP_RANGE_UNREAD};
  assign art_in  = has && in_lo && in_hi;
  assign endv    = single ? ARB_ALU_W'(req_q.article) : ARB_ALU_W'(req_q.range_end);
  assign fw      = AW'(first_off >> ARB_BIT_W);
  assign lw      = AW'(last_off >> ARB_BIT_W);

  always_comb begin
    lo_bit = (widx == fw) ? first_off[ARB_BIT_W-1:0] : '0;
    hi_bit = (widx == lw) ? last_off[ARB_BIT_W-1:0] : '1;
    for (int i = 0; i < ARB_WORD_W; i++) begin
      mask[i] = (ARB_BIT_W'(i) >= lo_bit) && (ARB_BIT_W'(i) <= hi_bit);
    end
    new_word = mk_read ? (ram_rdata | mask) : (ram_rdata & ~mask);
    pop      = popcount(ram_rdata ^ new_word);
  end

  always_comb begin
    if ((alu_res[ARB_ALU_W-1:ARB_CNT_W] != '0) ||
        (alu_res[ARB_CNT_W-1:0] == ARB_COUNT_MAX)) begin
      cnt_load = ARB_COUNT_MAX;
    end else begin
      cnt_load = alu_res[ARB_CNT_W-1:0] + 1'b1;
    end
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = ALU_SUB;
    case (state)
      ST_CAP: begin
        alu_a   = ARB_ALU_W'(wlo);
        alu_b   = ARB_ALU_W'(MAX_ARTICLES - 1);
        alu_sub = ALU_ADD;
      end
      ST_EMP: begin
        alu_a = ARB_ALU_W'(whi);
        alu_b = ARB_ALU_W'(wlo);
      end
      ST_HIC: begin
        alu_a = ARB_ALU_W'(whi);
        alu_b = cap;
      end
      ST_ALO: begin
        alu_a = ARB_ALU_W'(req_q.article);
        alu_b = ARB_ALU_W'(wlo);
      end
      ST_AHI: begin
        alu_a = hi;
        alu_b = ARB_ALU_W'(req_q.article);
      end
      ST_CLD: begin
        alu_a = hi;
        alu_b = ARB_ALU_W'(wlo);
      end
      ST_EHI: begin
        alu_a = hi;
        alu_b = endv;
      end
      ST_LOFF: begin
        alu_a = end_gt_hi ? hi : endv;
        alu_b = ARB_ALU_W'(wlo);
      end
      ST_ORD: begin
        alu_a = last_off;
        alu_b = first_off;
      end
      ST_CNT: begin
        alu_a   = ARB_ALU_W'(unread_total);
        alu_b   = ARB_ALU_W'(k);
        alu_sub = mk_read ? ALU_SUB : ALU_ADD;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx;
    ram_wdata = '0;
    ram_raddr = widx;
    case (state)
      ST_INIT, ST_CLR: begin
        ram_we = 1'b1;
      end
      ST_MOD: begin
        ram_we    = 1'b1;
        ram_wdata = new_word;
      end
      ST_ORD: begin
        ram_raddr = fw;
      end
      ST_CNT: begin
        ram_raddr = widx + 1'b1;
      end
      ST_FRD: begin
        ram_raddr = AW'(art_off >> ARB_BIT_W);
      end
      default: begin
      end
    endcase
  end

  arb_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .lt  (alu_lt)
  );

  arb_ram #(
    .WIDTH (ARB_WORD_W),
    .DEPTH (WORDS),
    .ADDR_W(AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      widx         <= '0;
      done         <= 1'b0;
      unread_total <= '0;
      wlo          <= ARB_WLO_RST;
      whi          <= ARB_WHI_RST;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == REG_WINDOW_HIGH) begin
          whi <= pwdata[30:0];
        end else begin
          wlo <= pwdata[30:0];
        end
      end
      case (state)
        ST_INIT: begin
          if (widx == LAST_WORD) begin
            widx  <= '0;
            state <= ST_IDLE;
          end else begin
            widx <= widx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (start) begin
            req_q <= req;
            state <= ST_CAP;
          end
        end
        ST_CAP: begin
          cap   <= alu_res;
          state <= ST_EMP;
        end
        ST_EMP: begin
          has   <= !alu_lt;
          state <= ST_HIC;
        end
        ST_HIC: begin
          hi    <= alu_lt ? ARB_ALU_W'(whi) : cap;
          state <= ST_ALO;
        end
        ST_ALO: begin
          in_lo     <= !alu_lt;
          art_off   <= alu_res;
          first_off <= alu_lt ? '0 : alu_res;
          state     <= ST_AHI;
        end
        ST_AHI: begin
          in_hi <= !alu_lt;
          if (req_q.op == OP_CLEAR) begin
            state <= ST_CLD;
          end else if (is_mark && has) begin
            state <= ST_EHI;
          end else begin
            state <= ST_FRD;
          end
        end
        ST_CLD: begin
          unread_total <= has ? cnt_load : '0;
          widx         <= '0;
          state        <= ST_CLR;
        end
        ST_CLR: begin
          if (widx == LAST_WORD) begin
            state <= ST_FRD;
          end else begin
            widx <= widx + 1'b1;
          end
        end
        ST_EHI: begin
          end_gt_hi <= alu_lt;
          state     <= ST_LOFF;
        end
        ST_LOFF: begin
          last_off <= alu_res;
          state    <= ST_ORD;
        end
        ST_ORD: begin
          if (alu_lt) begin
            state <= ST_FRD;
          end else begin
            widx  <= fw;
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          k     <= pop;
          state <= ST_CNT;
        end
        ST_CNT: begin
          if (mk_read) begin
            unread_total <= alu_lt ? '0 : alu_res[ARB_CNT_W-1:0];
          end else if (alu_res[ARB_ALU_W-1:ARB_CNT_W] != '0) begin
            unread_total <= ARB_COUNT_MAX;
          end else begin
            unread_total <= alu_res[ARB_CNT_W-1:0];
          end
          if (widx == lw) begin
            state <= ST_FRD;
          end else begin
            widx  <= widx + 1'b1;
            state <= ST_MOD;
          end
        end
        ST_FRD: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          rsp.is_read      <= art_in ? ram_rdata[art_off[ARB_BIT_W-1:0]] : 1'b1;
          rsp.in_window    <= art_in;
          rsp.unread_count <= unread_total;
          done             <= 1'b1;
          state            <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ARB_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "request taken but busy low")
  `ARB_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `ARB_ASSERT_IMP(a_out_read, clk, rst, done && !rsp.in_window, rsp.is_read, "outside not read")
  `ARB_ASSERT_IMP(a_idle_total, clk, rst, state == ST_IDLE && $past(state == ST_IDLE), $stable(unread_total), "count moved while idle")

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import arb_pkg::*;

  localparam int STORE_DEPTH = ARB_MAX_ARTICLES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = 16;
  localparam int MAX_GAP = 200;
  localparam int REPORT_LIMIT = 10;

  localparam logic [2:0] ADDR_WINDOW_LOW = 3'd0;
  localparam logic [2:0] ADDR_WINDOW_HIGH = 3'd4;
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [30:0] ARTICLE_MAX = 31'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  arb_req_t req;
  logic done;
  arb_rsp_t rsp;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [30:0] win_low;
  logic [30:0] win_high;
  logic [STORE_DEPTH-1:0] read_map;
  logic [ARB_CNT_W-1:0] unread_total;

  arb_rsp_t expected_status_q[$];
  arb_rsp_t status_want;

  int sender_idle_pct = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int window_settings = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  article_read_bitmap_core #(
    .MAX_ARTICLES(STORE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  function automatic bit window_bounds(output longint lo, output longint hi);
    longint cap;
    lo = longint'(win_low);
    hi = longint'(win_high);
    cap = lo + STORE_DEPTH - 1;
    if (hi < lo) return 1'b0;
    if (hi > cap) hi = cap;
    return 1'b1;
  endfunction

  function automatic void flip_bit(longint off, bit make_read);
    if (off >= STORE_DEPTH) return;
    if (make_read) begin
      if (!read_map[off] && unread_total != '0) unread_total--;
      read_map[off] = 1'b1;
    end else begin
      if (read_map[off] && unread_total != ARB_COUNT_MAX) unread_total++;
      read_map[off] = 1'b0;
    end
  endfunction

  function automatic void mark_span(longint first, longint last, bit make_read);
    longint lo;
    longint hi;
    if (!window_bounds(lo, hi)) return;
    if (last < first) return;
    if (first < lo) first = lo;
    if (last > hi) last = hi;
    for (longint a = first; a <= last; a++) flip_bit(a - lo, make_read);
  endfunction

  function automatic arb_rsp_t predict_status(arb_req_t r);
    arb_rsp_t s;
    longint lo;
    longint hi;
    longint art;
    longint fin;
    bit has;
    art = longint'(r.article);
    fin = longint'(r.range_end);
    case (r.op)
      OP_MARK_READ: mark_span(art, art, 1'b1);
      OP_MARK_UNREAD: mark_span(art, art, 1'b0);
      OP_RANGE_READ: mark_span(art, fin, 1'b1);
      OP_RANGE_UNREAD: mark_span(art, fin, 1'b0);
      OP_CLEAR: begin
        read_map = '0;
        if (window_bounds(lo, hi)) begin
          if (hi - lo + 1 > longint'(ARB_COUNT_MAX)) unread_total = ARB_COUNT_MAX;
          else unread_total = ARB_CNT_W'(hi - lo + 1);
        end else begin
          unread_total = '0;
        end
      end
      default: ;
    endcase
    has = window_bounds(lo, hi);
    s.in_window = has && art >= lo && art <= hi;
    s.is_read = s.in_window ? read_map[art - lo] : 1'b1;
    s.unread_count = unread_total;
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        status_want = expected_status_q.pop_front();
        results_checked++;
        if (rsp.is_read !== status_want.is_read || rsp.in_window !== status_want.in_window ||
            rsp.unread_count !== status_want.unread_count) begin
          report_mismatch($sformatf(
            "is_read %0b/%0b in_window %0b/%0b unread_count %0d/%0d (expected/actual)",
            status_want.is_read, rsp.is_read, status_want.in_window, rsp.in_window,
            status_want.unread_count, rsp.unread_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [30:0] article,
                              input logic [30:0] range_end);
    arb_req_t r;
    int gap;
    r.op = op;
    r.article = article;
    r.range_end = range_end;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    expected_status_q.push_back(predict_status(r));
    requests_sent++;
  endtask

  task automatic settle_idle();
    start <= 1'b0;
    forever begin
      @(posedge clk);
      if (expected_status_q.size() == 0 && !busy) break;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [30:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {1'($urandom_range(1)), value};
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (addr == ADDR_WINDOW_LOW) win_low = value;
    else win_high = value;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [31:0] got;
    apb_read(ADDR_WINDOW_LOW, got);
    if (got !== {1'b0, win_low}) begin
      report_mismatch($sformatf("window_low reads %0h, expected %0h", got, win_low));
    end
    apb_read(ADDR_WINDOW_HIGH, got);
    if (got !== {1'b0, win_high}) begin
      report_mismatch($sformatf("window_high reads %0h, expected %0h", got, win_high));
    end
  endtask

  task automatic set_window(input logic [30:0] lo, input logic [30:0] hi);
    settle_idle();
    apb_write(ADDR_WINDOW_LOW, lo);
    apb_write(ADDR_WINDOW_HIGH, hi);
    check_registers();
    window_settings++;
  endtask

  function automatic logic [30:0] pick_article();
    longint lo;
    longint hi;
    longint span;
    if ($urandom_range(99) < 15) return 31'($urandom);
    if (window_bounds(lo, hi)) span = hi - lo + 17;
    else span = 24;
    return 31'(longint'(win_low) - 8 + longint'($urandom_range(32'(span - 1))));
  endfunction

  task automatic random_request();
    logic [2:0] op;
    logic [30:0] art;
    logic [30:0] fin;
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) op = OP_QUERY;
    else if (pick < 45) op = OP_MARK_READ;
    else if (pick < 65) op = OP_MARK_UNREAD;
    else if (pick < 80) op = OP_RANGE_READ;
    else if (pick < 95) op = OP_RANGE_UNREAD;
    else if (pick < 97) op = OP_CLEAR;
    else op = pick[0] ? OP_SPARE_A : OP_SPARE_B;
    art = pick_article();
    pick = $urandom_range(99);
    if (pick < 70) fin = art + 31'($urandom_range(40));
    else if (pick < 85) fin = art + 31'($urandom_range(600));
    else if (pick < 93) fin = 31'($urandom);
    else fin = art - 31'($urandom_range(20, 1));
    send_request(op, art, fin);
  endtask

  task automatic test_reset_state();
    check_registers();
    send_request(OP_QUERY, 31'd0, 31'd0);
    // count is still zero here: the decrement must saturate
    send_request(OP_MARK_READ, 31'd5, 31'd0);
    send_request(OP_SPARE_A, 31'd5, 31'd5);
    send_request(OP_SPARE_B, ARTICLE_MAX, ARTICLE_MAX);
  endtask

  task automatic test_single_marks();
    send_request(OP_CLEAR, 31'd0, 31'd0);
    send_request(OP_MARK_READ, 31'd0, 31'd0);
    send_request(OP_MARK_READ, 31'd4095, 31'd0);
    send_request(OP_MARK_READ, 31'd4095, 31'd0);
    send_request(OP_MARK_UNREAD, 31'd0, 31'd0);
    send_request(OP_MARK_READ, 31'd4096, 31'd0);
    send_request(OP_MARK_UNREAD, ARTICLE_MAX, ARTICLE_MAX);
    send_request(OP_QUERY, 31'd4095, 31'd0);
  endtask

  task automatic test_ranges();
    send_request(OP_RANGE_READ, 31'd100, 31'd90);
    send_request(OP_RANGE_READ, 31'd4000, ARTICLE_MAX);
    send_request(OP_RANGE_UNREAD, 31'd4090, 31'd5000);
    send_request(OP_RANGE_READ, 31'd0, ARTICLE_MAX);
    send_request(OP_RANGE_UNREAD, 31'd10, 31'd20);
  endtask

  task automatic test_window_moves();
    // bits keep their offsets when the window slides
    set_window(31'd100, 31'd4195);
    send_request(OP_QUERY, 31'd100, 31'd0);
    send_request(OP_QUERY, 31'd4195, 31'd0);
    set_window(ARTICLE_MAX, ARTICLE_MAX);
    send_request(OP_CLEAR, ARTICLE_MAX, 31'd0);
    send_request(OP_MARK_READ, ARTICLE_MAX, 31'd0);
    set_window(31'd50, 31'd0);
    send_request(OP_CLEAR, 31'd50, 31'd0);
    send_request(OP_RANGE_UNREAD, 31'd0, ARTICLE_MAX);
    // window wider than the store gets cut
    set_window(31'd1000, ARTICLE_MAX);
    send_request(OP_CLEAR, 31'd1000, 31'd0);
    send_request(OP_QUERY, 31'd5096, 31'd0);
  endtask

  task automatic test_random_phase(input int items, input int idle_pct, input logic [30:0] lo,
                                   input logic [30:0] hi, input bit clear_first);
    set_window(lo, hi);
    sender_idle_pct = idle_pct;
    if (clear_first) send_request(OP_CLEAR, lo, lo);
    repeat (items) random_request();
  endtask

  initial begin
    logic [30:0] lo;
    start <= 1'b0;
    req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    win_low = ARB_WLO_RST;
    win_high = ARB_WHI_RST;
    read_map = '0;
    unread_total = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_single_marks();
    test_ranges();
    test_window_moves();

    test_random_phase(300, 0, 31'd0, 31'd4095, 1'b1);
    lo = 31'($urandom_range(32'h7FFF_0000));
    test_random_phase(300, 84, lo, lo + 31'($urandom_range(300, 7)), 1'b1);
    // keep the store across the move: no clear
    lo = 31'($urandom);
    test_random_phase(250, 19, lo, ARTICLE_MAX, 1'b0);
    lo = ARTICLE_MAX - 31'($urandom_range(100));
    test_random_phase(150, 0, lo, ARTICLE_MAX, 1'b1);
    lo = 31'($urandom_range(5000, 100));
    test_random_phase(100, 19, lo, lo - 31'($urandom_range(100, 1)), 1'b1);
    lo = 31'($urandom_range(32'h7FFF_FF00));
    test_random_phase(200, 84, lo, lo + 31'd7, 1'b1);

    settle_idle();
    if (expected_status_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_status_q.size()));
    end
    $display("Checked %0d results from %0d requests across %0d window settings",
             results_checked, requests_sent, window_settings);
    $display("Covered queries, single and range marks, clears, spare op codes, empty and cut windows");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/arb_pkg.sv
sv/arb_ram.sv
sv/arb_alu.sv
sv/article_read_bitmap_core.sv
test/tb_top.sv
